// ===== sv/ssem_pkg.sv =====
`timescale 1ns / 1ps

package ssem_pkg;

  localparam int ADDR_BITS  = 13;
  localparam int WORD_W     = 32;
  localparam int DEPTH      = 1 << ADDR_BITS;
  localparam int FN_W       = 3;
  localparam int FN_LSB     = 13;
  localparam int CMD_W      = 2;
  localparam int IN_ADDR_W  = 13;
  localparam int IN_W       = 48;
  localparam int OUT_USED_W = 3 * WORD_W + FN_W + 2;
  localparam int OUT_W      = 104;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [WORD_W-1:0]    word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [FN_W-1:0] {
    FN_JMP  = 3'd0,
    FN_JRP  = 3'd1,
    FN_LDN  = 3'd2,
    FN_STO  = 3'd3,
    FN_SUB  = 3'd4,
    FN_SUBA = 3'd5,
    FN_CMP  = 3'd6,
    FN_STP  = 3'd7
  } fn_e;

  typedef enum logic [2:0] {
    UPC_IDLE     = 3'd0,
    UPC_WRITE    = 3'd1,
    UPC_READ     = 3'd2,
    UPC_READ_CAP = 3'd3,
    UPC_FETCH    = 3'd4,
    UPC_DECODE   = 3'd5,
    UPC_EXEC     = 3'd6,
    UPC_DONE     = 3'd7
  } upc_e;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_JUMP     = 2'd1,
    SEQ_DISPATCH = 2'd2,
    SEQ_WAIT_OUT = 2'd3
  } seq_e;

  typedef enum logic [1:0] {
    ASEL_IN      = 2'd0,
    ASEL_PC_NEXT = 2'd1,
    ASEL_INSTR   = 2'd2,
    ASEL_OPND    = 2'd3
  } asel_e;

  typedef struct packed {
    logic  ram_wr;
    asel_e asel;
    logic  load_in;
    logic  cr_inc;
    logic  ir_load;
    logic  rd_load;
    logic  exec;
    logic  out_load;
    seq_e  seq;
    upc_e  target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    cmd_e cmd;
    logic halted;
    logic out_free;
  } seq_in_t;

  typedef struct packed {
    logic              stopped;
    logic              executed;
    logic [FN_W-1:0]   function_done;
    word_t             control_value;
    word_t             accumulator_value;
    word_t             read_data;
  } res_t;

  function automatic ctrl_t ucode(upc_e a);
    ctrl_t c;
    c = '0;
    unique case (a)
      UPC_IDLE: begin
        c.load_in = 1'b1;
        c.seq     = SEQ_DISPATCH;
      end
      UPC_WRITE: begin
        c.ram_wr = 1'b1;
        c.asel   = ASEL_IN;
        c.seq    = SEQ_JUMP;
        c.target = UPC_DONE;
      end
      UPC_READ: begin
        c.asel = ASEL_IN;
        c.seq  = SEQ_NEXT;
      end
      UPC_READ_CAP: begin
        c.rd_load = 1'b1;
        c.seq     = SEQ_JUMP;
        c.target  = UPC_DONE;
      end
      UPC_FETCH: begin
        c.asel   = ASEL_PC_NEXT;
        c.cr_inc = 1'b1;
        c.seq    = SEQ_NEXT;
      end
      UPC_DECODE: begin
        c.asel    = ASEL_INSTR;
        c.ir_load = 1'b1;
        c.seq     = SEQ_NEXT;
      end
      UPC_EXEC: begin
        c.asel = ASEL_OPND;
        c.exec = 1'b1;
        c.seq  = SEQ_NEXT;
      end
      UPC_DONE: begin
        c.out_load = 1'b1;
        c.seq      = SEQ_WAIT_OUT;
        c.target   = UPC_IDLE;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/ssem_ram.sv =====
`timescale 1ns / 1ps

module ssem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== sv/ssem_useq.sv =====
`timescale 1ns / 1ps

module ssem_useq import ssem_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  seq_in_t sin_i,
  output logic    ready_o,
  output ctrl_t   ctrl_o
);

  upc_e  upc_q, upc_d;
  ctrl_t word;

  always_comb begin
    word   = ucode(upc_q);
    ctrl_o = word;
    ctrl_o.load_in  = word.load_in & sin_i.in_valid;
    ctrl_o.out_load = word.out_load & sin_i.out_free;
    ready_o = (word.seq == SEQ_DISPATCH);
  end

  always_comb begin
    upc_d = upc_q;
    unique case (word.seq)
      SEQ_NEXT: upc_d = upc_e'(upc_q + 3'd1);
      SEQ_JUMP: upc_d = word.target;
      SEQ_DISPATCH: begin
        if (sin_i.in_valid) begin
          unique case (sin_i.cmd)
            CMD_WRITE: upc_d = UPC_WRITE;
            CMD_READ:  upc_d = UPC_READ;
            CMD_STEP:  upc_d = sin_i.halted ? UPC_DONE : UPC_FETCH;
            default:   upc_d = UPC_DONE;
          endcase
        end
      end
      SEQ_WAIT_OUT: begin
        if (sin_i.out_free) begin
          upc_d = word.target;
        end
      end
      default: upc_d = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== sv/ssem_dpath.sv =====
`timescale 1ns / 1ps

module ssem_dpath import ssem_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  logic [IN_ADDR_W-1:0] in_addr_i,
  input  word_t                in_data_i,
  input  word_t                ram_rdata_i,
  output logic                 ram_we_o,
  output addr_t                ram_addr_o,
  output word_t                ram_wdata_o,
  output logic                 halted_o,
  output res_t                 res_o
);

  addr_t           addr_q;
  word_t           wdata_q;
  word_t           cr_q, cr_d;
  word_t           acc_q, acc_d;
  word_t           ir_q;
  word_t           rd_q;
  logic [FN_W-1:0] fn_q;
  logic            exe_q;
  logic            halted_q, halted_d;
  word_t           cr_next;
  fn_e             fn;

  assign cr_next = cr_q + word_t'(1);
  assign fn      = fn_e'(ir_q[FN_LSB +: FN_W]);

  always_comb begin
    unique case (ctrl_i.asel)
      ASEL_IN:      ram_addr_o = addr_q;
      ASEL_PC_NEXT: ram_addr_o = cr_next[ADDR_BITS-1:0];
      ASEL_INSTR:   ram_addr_o = ram_rdata_i[ADDR_BITS-1:0];
      ASEL_OPND:    ram_addr_o = ir_q[ADDR_BITS-1:0];
      default:      ram_addr_o = addr_q;
    endcase
  end

  assign ram_we_o    = ctrl_i.ram_wr | (ctrl_i.exec & (fn == FN_STO));
  assign ram_wdata_o = ctrl_i.exec ? acc_q : wdata_q;

  // ram_rdata_i holds the operand word during exec
  always_comb begin
    cr_d     = cr_q;
    acc_d    = acc_q;
    halted_d = halted_q;
    if (ctrl_i.cr_inc) begin
      cr_d = cr_next;
    end
    if (ctrl_i.exec) begin
      unique case (fn)
        FN_JMP:          cr_d = ram_rdata_i;
        FN_JRP:          cr_d = cr_q + ram_rdata_i;
        FN_LDN:          acc_d = word_t'(0) - ram_rdata_i;
        FN_STO:          acc_d = acc_q;
        FN_SUB, FN_SUBA: acc_d = acc_q - ram_rdata_i;
        FN_CMP: begin
          if (acc_q[WORD_W-1]) begin
            cr_d = cr_next;
          end
        end
        FN_STP:          halted_d = 1'b1;
        default:         halted_d = halted_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q     <= '0;
      acc_q    <= '0;
      halted_q <= 1'b0;
      fn_q     <= '0;
      exe_q    <= 1'b0;
    end else begin
      cr_q     <= cr_d;
      acc_q    <= acc_d;
      halted_q <= halted_d;
      if (ctrl_i.load_in) begin
        fn_q  <= '0;
        exe_q <= 1'b0;
      end else if (ctrl_i.exec) begin
        fn_q  <= ir_q[FN_LSB +: FN_W];
        exe_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      addr_q  <= in_addr_i[ADDR_BITS-1:0];
      wdata_q <= in_data_i;
      rd_q    <= '0;
    end else if (ctrl_i.rd_load) begin
      rd_q <= ram_rdata_i;
    end
    if (ctrl_i.ir_load) begin
      ir_q <= ram_rdata_i;
    end
  end

  assign halted_o = halted_q;

  always_comb begin
    res_o.stopped           = halted_q;
    res_o.executed          = exe_q;
    res_o.function_done     = fn_q;
    res_o.control_value     = cr_q;
    res_o.accumulator_value = acc_q;
    res_o.read_data         = rd_q;
  end

endmodule

// ===== sv/ssem_processor_step.sv =====
`timescale 1ns / 1ps

// Small stored-program processor with an 8K x 32 word store.
// Input beats carry a command in s_axis_tuser: write a store word, read a
// store word, or execute one instruction step. Every input beat yields
// exactly one output beat with the read word, accumulator, control
// register, executed function code, executed flag and stop flag.
// One item is in flight at a time; a microcode sequencer steps the single
// store port. A write passes through the WRITE and DONE steps, a read
// through READ, READ_CAP and DONE, a step through FETCH, DECODE, EXEC and
// DONE, and a step while stopped or an unused command goes straight to DONE.
// s_axis_tready rises together with output tvalid; the fetch, operand read
// and optional store write each use the store port in a separate step.
// The result sits in an output register: the next item is accepted while it
// waits. If the receiver stalls with a result still held, the sequencer
// waits in its final step until the register frees up.
// Reset clears accumulator, control register and stop flag; store contents
// are undefined until written.
module ssem_processor_step import ssem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [12:0] address, [44:13] write_data, zero padded
  input  logic [IN_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0] s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [31:0] read_data, [63:32] accumulator_value, [95:64] control_value,
  // [98:96] function_done, [99] executed, [100] stopped, zero padded
  output logic [OUT_W-1:0] m_axis_tdata
);

  ctrl_t            ctrl;
  seq_in_t          sin;
  res_t             res;
  logic             ram_we;
  addr_t            ram_addr;
  word_t            ram_wdata;
  word_t            ram_rdata;
  logic             halted;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  always_comb begin
    sin.in_valid = s_axis_tvalid;
    sin.cmd      = cmd_e'(s_axis_tuser);
    sin.halted   = halted;
    sin.out_free = !out_valid_q || m_axis_tready;
  end

  ssem_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sin_i  (sin),
    .ready_o(s_axis_tready),
    .ctrl_o (ctrl)
  );

  ssem_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_addr_i  (s_axis_tdata[IN_ADDR_W-1:0]),
    .in_data_i  (s_axis_tdata[IN_ADDR_W +: WORD_W]),
    .ram_rdata_i(ram_rdata),
    .ram_we_o   (ram_we),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .halted_o   (halted),
    .res_o      (res)
  );

  ssem_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q <= {{(OUT_W - OUT_USED_W){1'b0}}, res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sequencer still ready after accepting a beat");

  a_fn_only_when_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[99] || (m_axis_tdata[98:96] == 3'd0)))
    else $error("function code reported without execution");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(halted))
    else $error("stop flag cleared outside reset");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result loaded over an unaccepted beat");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ssem_pkg::*;

  localparam int PLANNER = 0;
  localparam int CHECKER = 1;

  typedef struct {
    cmd_e  cmd;
    addr_t addr;
    word_t data;
  } beat_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0] s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  // two copies of the machine: one steers stimulus, one scores the DUT
  word_t store_m   [2][DEPTH];
  bit    written_m [2][DEPTH];
  word_t acc_m     [2] = '{default: '0};
  word_t cr_m      [2] = '{default: '0};
  bit    halt_m    [2];

  beat_t stim_q[$];
  res_t  pending_res[$];
  addr_t wr_list[$];

  int unsigned n_items = 0;
  int unsigned n_res   = 0;
  int unsigned n_err   = 0;
  int unsigned tx_gap  = 0;
  int unsigned rx_gap  = 0;
  logic        in_fire = 1'b0;
  logic        rx_hold = 1'b0;
  res_t        got, want;
  beat_t       nxt;

  ssem_processor_step u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic res_t ssem_exec(int m, cmd_e cmd, addr_t a, word_t d);
    res_t            r;
    word_t           ins, opw;
    addr_t           opa;
    logic [FN_W-1:0] fn;
    r = '0;
    case (cmd)
      CMD_WRITE: begin
        store_m[m][a]   = d;
        written_m[m][a] = 1'b1;
      end
      CMD_READ: r.read_data = store_m[m][a];
      CMD_STEP: begin
        if (!halt_m[m]) begin
          cr_m[m] = cr_m[m] + 1;
          ins = store_m[m][cr_m[m][ADDR_BITS-1:0]];
          opa = ins[ADDR_BITS-1:0];
          fn  = ins[FN_LSB +: FN_W];
          opw = store_m[m][opa];
          case (fn_e'(fn))
            FN_JMP:          cr_m[m] = opw;
            FN_JRP:          cr_m[m] = cr_m[m] + opw;
            FN_LDN:          acc_m[m] = -opw;
            FN_STO: begin
              store_m[m][opa]   = acc_m[m];
              written_m[m][opa] = 1'b1;
            end
            FN_SUB, FN_SUBA: acc_m[m] = acc_m[m] - opw;
            FN_CMP:          if (acc_m[m][WORD_W-1]) cr_m[m] = cr_m[m] + 1;
            default:         halt_m[m] = 1'b1;
          endcase
          r.function_done = fn;
          r.executed      = 1'b1;
        end
      end
      default: ;
    endcase
    r.accumulator_value = acc_m[m];
    r.control_value     = cr_m[m];
    r.stopped           = halt_m[m];
    return r;
  endfunction

  function automatic void post(cmd_e c, addr_t a, word_t d);
    if (c == CMD_WRITE && !written_m[PLANNER][a]) wr_list.push_back(a);
    void'(ssem_exec(PLANNER, c, a, d));
    stim_q.push_back('{c, a, d});
    if (c != CMD_NONE) n_items++;
  endfunction

  function automatic word_t instr(fn_e fn, addr_t op);
    word_t w;
    w = $urandom;
    w[FN_LSB +: FN_W]  = fn;
    w[ADDR_BITS-1:0]   = op;
    return w;
  endfunction

  function automatic word_t pick_word();
    return ($urandom_range(0, 3) == 0) ? word_t'($urandom_range(0, 31)) : word_t'($urandom);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((n_res / 80) % 3 == 1) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void cmp_field(string name, logic [WORD_W-1:0] exp_v,
                                    logic [WORD_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      n_err++;
    end
  endfunction

  // stimulus plan, then end of run
  initial begin
    int unsigned r, nsteps;
    addr_t       fa, opa;
    word_t       iw;
    bit          ok;

    post(CMD_WRITE, addr_t'(DEPTH - 1), '1);
    post(CMD_WRITE, '0, '0);
    post(CMD_READ, addr_t'(DEPTH - 1), '0);
    post(CMD_READ, '0, '1);
    post(CMD_WRITE, addr_t'(100), word_t'(5));
    post(CMD_WRITE, addr_t'(1), instr(FN_LDN, addr_t'(100)));
    post(CMD_STEP, '0, '0);
    // accumulator negative here, so the compare skips
    post(CMD_WRITE, addr_t'(2), instr(FN_CMP, addr_t'(100)));
    post(CMD_STEP, '1, '1);
    post(CMD_WRITE, addr_t'(4), instr(FN_SUB, addr_t'(DEPTH - 1)));
    post(CMD_STEP, '0, '0);
    post(CMD_WRITE, addr_t'(5), instr(FN_SUBA, '0));
    post(CMD_STEP, '0, '0);
    post(CMD_WRITE, addr_t'(200), 32'h1234_5678);
    post(CMD_WRITE, addr_t'(6), instr(FN_STO, addr_t'(200)));
    post(CMD_STEP, '0, '0);
    post(CMD_READ, addr_t'(200), '0);
    post(CMD_WRITE, addr_t'(7), instr(FN_JRP, addr_t'(100)));
    post(CMD_STEP, '0, '0);
    // jump to all ones: next fetch wraps to address zero
    post(CMD_WRITE, addr_t'(13), instr(FN_JMP, addr_t'(DEPTH - 1)));
    post(CMD_STEP, '0, '0);
    post(CMD_STEP, '0, '0);
    post(CMD_NONE, '1, '1);

    while (n_items < 600) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        nsteps = $urandom_range(1, 4);
        repeat (nsteps) begin
          fa = addr_t'(cr_m[PLANNER] + 1);
          iw = store_m[PLANNER][fa];
          ok = written_m[PLANNER][fa] && written_m[PLANNER][iw[ADDR_BITS-1:0]] &&
               iw[FN_LSB +: FN_W] != FN_STP;
          if (!ok || $urandom_range(0, 2) == 0) begin
            if (wr_list.size() == 0 || $urandom_range(0, 1) == 0) begin
              opa = addr_t'($urandom_range(0, DEPTH - 1));
              post(CMD_WRITE, opa, pick_word());
            end else begin
              opa = wr_list[$urandom_range(0, wr_list.size() - 1)];
            end
            post(CMD_WRITE, fa, instr(fn_e'($urandom_range(0, FN_CMP)), opa));
          end
          post(CMD_STEP, addr_t'($urandom_range(0, DEPTH - 1)), $urandom);
        end
      end else if (r < 70) begin
        post(CMD_READ, wr_list[$urandom_range(0, wr_list.size() - 1)], $urandom);
      end else if (r < 85) begin
        post(CMD_WRITE, addr_t'($urandom_range(0, DEPTH - 1)), pick_word());
      end else if (r < 92) begin
        post(CMD_NONE, addr_t'($urandom_range(0, DEPTH - 1)), $urandom);
      end else begin
        opa = addr_t'($urandom_range(0, DEPTH - 1));
        post(CMD_WRITE, opa, $urandom);
        post(CMD_READ, opa, $urandom);
      end
    end

    // stop instruction, then steps while stopped
    fa = addr_t'(cr_m[PLANNER] + 1);
    post(CMD_WRITE, fa, instr(FN_STP, wr_list[0]));
    post(CMD_STEP, '0, '0);
    repeat (3) post(CMD_STEP, addr_t'($urandom_range(0, DEPTH - 1)), $urandom);
    post(CMD_READ, fa, '0);
    post(CMD_WRITE, fa, $urandom);
    post(CMD_NONE, '1, '1);
    post(CMD_READ, fa, '0);
    post(CMD_STEP, '0, '0);

    while (stim_q.size() != 0 || s_axis_tvalid || pending_res.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // long receiver hold-off so the input side backs up
  initial begin
    while (n_res < 120) @(negedge clk_i);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (80) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          nxt = stim_q.pop_front();
          s_axis_tuser  <= nxt.cmd;
          s_axis_tdata  <= {{(IN_W - IN_ADDR_W - WORD_W){1'b0}}, nxt.data, nxt.addr};
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // monitor: predict on input beat, check on output beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        pending_res.push_back(ssem_exec(CHECKER, cmd_e'(s_axis_tuser),
                                        s_axis_tdata[IN_ADDR_W-1:0],
                                        s_axis_tdata[IN_ADDR_W +: WORD_W]));
      if (m_axis_tvalid && m_axis_tready) begin
        n_res++;
        got = res_t'(m_axis_tdata[OUT_USED_W-1:0]);
        if (pending_res.size() == 0) begin
          $error("output beat with no result pending: %h", m_axis_tdata);
          n_err++;
        end else begin
          want = pending_res.pop_front();
          cmp_field("read_data", want.read_data, got.read_data);
          cmp_field("accumulator_value", want.accumulator_value, got.accumulator_value);
          cmp_field("control_value", want.control_value, got.control_value);
          cmp_field("function_done", word_t'(want.function_done),
                    word_t'(got.function_done));
          cmp_field("executed", word_t'(want.executed), word_t'(got.executed));
          cmp_field("stopped", word_t'(want.stopped), word_t'(got.stopped));
        end
      end
    end
  end

endmodule
